/* rtl/snem_pkg.sv */
package snem_pkg;

	localparam int NAME_BYTES = 8;
	localparam int EXT_BYTES  = 3;

	typedef logic [2:0] verdict_t;

	localparam verdict_t V_NONE       = 3'd0;
	localparam verdict_t V_MATCH      = 3'd1;
	localparam verdict_t V_EMPTY_SLOT = 3'd2;
	localparam verdict_t V_END        = 3'd3;
	localparam verdict_t V_IGNORED    = 3'd4;

	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t REG_PATTERN_NAME = 3'd0;
	localparam cfg_index_t REG_PATTERN_EXT  = 3'd1;
	localparam cfg_index_t REG_ALLOWED_ATTR = 3'd2;
	localparam cfg_index_t REG_MATCH_MODE   = 3'd3;
	localparam cfg_index_t REG_FIND_EMPTY   = 3'd4;

	localparam logic [63:0] PATTERN_NAME_RESET = 64'h2020_2020_2020_2020;
	localparam logic [23:0] PATTERN_EXT_RESET  = 24'h20_2020;
	localparam logic [23:0] EXT_BLANK          = 24'h20_2020;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_STAR    = 8'h2A;
	localparam logic [7:0] CHAR_QUESTION = 8'h3F;
	localparam logic [7:0] MARK_EMPTY   = 8'h00;
	localparam logic [7:0] MARK_DELETED = 8'hE5;

	localparam logic [7:0] ATTR_KEEP    = 8'h3F;
	localparam logic [7:0] ATTR_LABEL   = 8'h08;
	localparam logic [7:0] ATTR_LONG    = 8'h0F;
	localparam int         ATTR_HIDDEN_BIT = 1;

	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

/* rtl/short_name_entry_matcher.sv */
// Short-name directory entry matcher.
// Input channel (in_valid/in_ready): one directory entry per transfer, with
// its eight name bytes, three extension bytes, attribute byte and a
// start_search flag that restarts the entry index and clears the finished flag.
// Output channel (out_valid/out_ready): one verdict and entry index per entry,
// in input order.
// Configuration: cfg_we writes cfg_data into the register cfg_index selects
// (0 pattern name, 1 pattern extension, 2 allowed attributes, 3 match mode,
// 4 find empty); write only while no entry is in flight.
// Pipeline: an entry passes the input register, then the result register.
// Throughput: one entry per cycle while the receiver does not stall; the
// eleven byte compares and the index update sit between those two registers.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready drops only when both are full.
// Reset: both registers empty, index zero, search not finished, pattern all
// spaces, mode 0, no allowed attributes, find-empty off.
module short_name_entry_matcher
	import snem_pkg::*;
#(
	parameter int INDEX_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] entry_name,
	input  logic [23:0] entry_ext,
	input  logic [7:0]  entry_attributes,
	input  logic        start_search,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  verdict,
	output logic [15:0] entry_index,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] pattern_name_q;
	logic [23:0] pattern_ext_q;
	logic [7:0]  allowed_attr_q;
	logic        match_mode_q;
	logic        find_empty_q;

	logic [INDEX_BITS-1:0] index_q;
	logic                  finished_q;

	logic        valid_s1;
	logic [63:0] name_s1;
	logic [23:0] ext_s1;
	logic [7:0]  attr_s1;
	logic        start_s1;

	logic        out_valid_q;
	verdict_t    verdict_q;
	logic [15:0] index_out_q;

	logic                  adv_s1;
	logic [INDEX_BITS-1:0] index_eff;
	logic                  finished_eff;
	verdict_t              verdict_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_name_q <= PATTERN_NAME_RESET;
			pattern_ext_q  <= PATTERN_EXT_RESET;
			allowed_attr_q <= '0;
			match_mode_q   <= 1'b0;
			find_empty_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_NAME: pattern_name_q <= cfg_data;
				REG_PATTERN_EXT:  pattern_ext_q  <= cfg_data[23:0];
				REG_ALLOWED_ATTR: allowed_attr_q <= cfg_data[7:0];
				REG_MATCH_MODE:   match_mode_q   <= cfg_data[0];
				REG_FIND_EMPTY:   find_empty_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv_s1   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			name_s1  <= entry_name;
			ext_s1   <= entry_ext;
			attr_s1  <= entry_attributes;
			start_s1 <= start_search;
		end
	end

	assign index_eff    = start_s1 ? '0 : index_q;
	assign finished_eff = start_s1 ? 1'b0 : finished_q;

	always_comb begin
		logic [23:0] ext;
		logic [7:0]  attr;
		logic [7:0]  pb;
		logic [7:0]  eb;
		logic        exact_ok;
		logic        wild_name_ok;
		logic        wild_ext_ok;
		logic        star_seen;
		logic        byte_ok;

		ext  = (ext_s1[7:0] == CHAR_SPACE) ? EXT_BLANK : ext_s1;
		attr = attr_s1 & ATTR_KEEP;

		exact_ok     = 1'b1;
		wild_name_ok = 1'b1;
		star_seen    = 1'b0;
		for (int k = 0; k < NAME_BYTES; k++) begin
			pb = pattern_name_q[8*k +: 8];
			eb = name_s1[8*k +: 8];
			if (fold(eb) != fold(pb)) begin
				exact_ok = 1'b0;
			end
			star_seen = star_seen || (pb == CHAR_STAR);
			byte_ok   = (pb == CHAR_QUESTION) || (fold(eb) == fold(pb));
			if (!star_seen && !byte_ok) begin
				wild_name_ok = 1'b0;
			end
		end

		wild_ext_ok = 1'b1;
		star_seen   = 1'b0;
		for (int k = 0; k < EXT_BYTES; k++) begin
			pb = pattern_ext_q[8*k +: 8];
			eb = ext[8*k +: 8];
			if (fold(eb) != fold(pb)) begin
				exact_ok = 1'b0;
			end
			star_seen = star_seen || (pb == CHAR_STAR);
			byte_ok   = (pb == CHAR_QUESTION) || (fold(eb) == fold(pb));
			if (!star_seen && !byte_ok) begin
				wild_ext_ok = 1'b0;
			end
		end

		verdict_s1 = V_NONE;
		if (finished_eff) begin
			verdict_s1 = V_IGNORED;
		end else if (name_s1[7:0] == MARK_EMPTY) begin
			verdict_s1 = V_END;
		end else if (name_s1[7:0] == MARK_DELETED) begin
			verdict_s1 = find_empty_q ? V_EMPTY_SLOT : V_NONE;
		end else if (!match_mode_q) begin
			if (attr != ATTR_LABEL && !attr[ATTR_HIDDEN_BIT] && exact_ok) begin
				verdict_s1 = V_MATCH;
			end
		end else begin
			if ((attr & ~allowed_attr_q) == '0 && attr != ATTR_LONG &&
					wild_name_ok && wild_ext_ok) begin
				verdict_s1 = V_MATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q    <= '0;
			finished_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			if (verdict_s1 == V_NONE) begin
				index_q <= index_eff + 1'b1;
			end else begin
				index_q <= index_eff;
			end
			finished_q <= finished_eff || (verdict_s1 != V_NONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			verdict_q   <= verdict_s1;
			index_out_q <= 16'(index_eff);
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign entry_index = index_out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 && finished_q && !start_s1
		|=> out_valid && verdict == V_IGNORED)
		else $error("finished search did not report an ignored entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 && !start_s1
		|=> index_q == $past(index_q) || index_q == INDEX_BITS'($past(index_q) + 1'b1))
		else $error("entry index moved by more than one");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 &&
		(verdict_s1 == V_MATCH || verdict_s1 == V_EMPTY_SLOT || verdict_s1 == V_END)
		|=> finished_q)
		else $error("finishing verdict did not end the search");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict <= V_IGNORED)
		else $error("verdict code out of range");

endmodule
